// ----- rtl/ltpq_pkg.sv -----
// Package for the linked task pool and queue unit.
// Holds the pool size, field widths, codes, state and command types.
// Used by every module of the block; depends on nothing.
package ltpq_pkg;

  localparam int POOL_ENTRIES = 1024;
  localparam int IDX_W        = $clog2(POOL_ENTRIES);
  localparam int LINK_W       = $clog2(POOL_ENTRIES + 1);

  localparam int MODE_W   = 2;
  localparam int HANDLE_W = 10;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_ENTRIES);

  localparam logic [KIND_W-1:0] KIND_PASS = 3'd4;

  localparam logic [STATUS_W-1:0] STS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_PUSH  = 2'd2,
    OP_POP   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_A3,
    ST_A4,
    ST_F3,
    ST_F4,
    ST_P3,
    ST_WB
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_A2,
    CMD_A3,
    CMD_A4,
    CMD_F2,
    CMD_F3,
    CMD_F4,
    CMD_P2,
    CMD_P3,
    CMD_Q2,
    CMD_FAIL_ALLOC,
    CMD_FAIL_POP,
    CMD_WB
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    op_t  op;
    logic alloc_ok;
    logic free_ok;
    logic push_ok;
    logic pop_ok;
  } dp_stat_t;

endpackage

// ----- rtl/ltpq_ctrl.sv -----
// Controller state machine of the linked task pool and queue unit.
// Sequences the clearing pass and the steps of each operation.
// Depends on ltpq_pkg.
module ltpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ltpq_pkg::dp_stat_t stat,
  output ltpq_pkg::cmd_t     cmd
);
  import ltpq_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = CMD_NONE;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_CLEAR: begin
        cmd = CMD_CLEAR;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = ST_WB;
        case (stat.op)
          OP_ALLOC: begin
            if (stat.alloc_ok) begin
              cmd        = CMD_A2;
              state_next = ST_A3;
            end else begin
              cmd = CMD_FAIL_ALLOC;
            end
          end
          OP_FREE: begin
            if (stat.free_ok) begin
              cmd        = CMD_F2;
              state_next = ST_F3;
            end
          end
          OP_PUSH: begin
            if (stat.push_ok) begin
              cmd        = CMD_P2;
              state_next = ST_P3;
            end
          end
          OP_POP: begin
            if (stat.pop_ok) begin
              cmd = CMD_Q2;
            end else begin
              cmd = CMD_FAIL_POP;
            end
          end
          default: begin
            cmd = CMD_NONE;
          end
        endcase
      end
      ST_A3: begin
        cmd        = CMD_A3;
        state_next = ST_A4;
      end
      ST_A4: begin
        cmd        = CMD_A4;
        state_next = ST_WB;
      end
      ST_F3: begin
        cmd        = CMD_F3;
        state_next = ST_F4;
      end
      ST_F4: begin
        cmd        = CMD_F4;
        state_next = ST_WB;
      end
      ST_P3: begin
        cmd        = CMD_P3;
        state_next = ST_WB;
      end
      ST_WB: begin
        if (!out_valid || !out_stall) begin
          cmd            = CMD_WB;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/ltpq_datapath.sv -----
// Datapath of the linked task pool and queue unit: link memories, flag
// memories, list heads, counters and the result word register.
// Depends on ltpq_pkg.
module ltpq_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  ltpq_pkg::cmd_t                   cmd,
  output ltpq_pkg::dp_stat_t               stat,
  input  logic [ltpq_pkg::MODE_W-1:0]      mode,
  input  logic [ltpq_pkg::HANDLE_W-1:0]    handle,
  input  logic [ltpq_pkg::KIND_W-1:0]      task_kind,
  output logic [ltpq_pkg::STATUS_W-1:0]    status,
  output logic [ltpq_pkg::HANDLE_W-1:0]    handle_out,
  output logic [ltpq_pkg::KIND_W-1:0]      kind_out,
  output logic [ltpq_pkg::COUNT_W-1:0]     active_count,
  output logic [ltpq_pkg::COUNT_W-1:0]     queued_count,
  output logic [ltpq_pkg::HANDLE_W-1:0]    list_head,
  output logic                             active_empty
);
  import ltpq_pkg::*;

  logic [LINK_W-1:0] next_mem   [POOL_ENTRIES];
  logic [LINK_W-1:0] prev_mem   [POOL_ENTRIES];
  logic [LINK_W-1:0] qnext_mem  [POOL_ENTRIES];
  logic [KIND_W-1:0] kind_mem   [POOL_ENTRIES];
  logic              active_mem [POOL_ENTRIES];
  logic              queued_mem [POOL_ENTRIES];

  logic [LINK_W-1:0] spare_head, act_head, qhead, qtail, alloc_cnt, qlen;
  logic [IDX_W-1:0]  clr_idx;

  op_t               op;
  logic [IDX_W-1:0]  cur;
  logic [KIND_W-1:0] kind_in;
  logic              in_pool;
  logic [LINK_W-1:0] rd_next, rd_prev, rd_qnext;
  logic [KIND_W-1:0] rd_kind;
  logic              rd_active, rd_queued;

  logic [STATUS_W-1:0] pend_status;
  logic [IDX_W-1:0]    pend_hout;
  logic [KIND_W-1:0]   pend_kout;

  logic [IDX_W-1:0]  hidx, ra_pool, ra_q;
  logic [LINK_W-1:0] cur_link;

  logic              nx_we, pv_we, qn_we, kd_we, ac_we, qd_we;
  logic [IDX_W-1:0]  nx_wa, pv_wa, qn_wa, kd_wa, ac_wa, qd_wa;
  logic [LINK_W-1:0] nx_wd, pv_wd, qn_wd;
  logic [KIND_W-1:0] kd_wd;
  logic              ac_wd, qd_wd;

  assign hidx     = IDX_W'(handle);
  assign ra_pool  = (op_t'(mode) == OP_ALLOC) ? spare_head[IDX_W-1:0] : hidx;
  assign ra_q     = qhead[IDX_W-1:0];
  assign cur_link = LINK_W'(cur);

  assign stat.clr_last = (clr_idx == IDX_W'(POOL_ENTRIES - 1));
  assign stat.op       = op;
  assign stat.alloc_ok = (alloc_cnt < LINK_W'(POOL_ENTRIES)) && (spare_head != NIL);
  assign stat.free_ok  = in_pool && rd_active;
  assign stat.push_ok  = in_pool && rd_active && !rd_queued;
  assign stat.pop_ok   = (qlen != '0) && (qhead != NIL);

  always_comb begin
    nx_we = 1'b0; nx_wa = cur; nx_wd = NIL;
    pv_we = 1'b0; pv_wa = cur; pv_wd = NIL;
    qn_we = 1'b0; qn_wa = cur; qn_wd = NIL;
    kd_we = 1'b0; kd_wa = cur; kd_wd = kind_in;
    ac_we = 1'b0; ac_wa = cur; ac_wd = 1'b0;
    qd_we = 1'b0; qd_wa = cur; qd_wd = 1'b0;
    case (cmd)
      CMD_CLEAR: begin
        nx_we = 1'b1; nx_wa = clr_idx; nx_wd = LINK_W'(clr_idx) + LINK_W'(1);
        pv_we = 1'b1; pv_wa = clr_idx;
        pv_wd = (clr_idx == '0) ? NIL : LINK_W'(clr_idx) - LINK_W'(1);
        qn_we = 1'b1; qn_wa = clr_idx; qn_wd = NIL;
        kd_we = 1'b1; kd_wa = clr_idx; kd_wd = KIND_PASS;
        ac_we = 1'b1; ac_wa = clr_idx; ac_wd = 1'b0;
        qd_we = 1'b1; qd_wa = clr_idx; qd_wd = 1'b0;
      end
      CMD_A2: begin
        nx_we = 1'b1; nx_wa = cur; nx_wd = act_head;
        pv_we = (rd_next != NIL); pv_wa = rd_next[IDX_W-1:0]; pv_wd = NIL;
      end
      CMD_A3: begin
        pv_we = (act_head != NIL); pv_wa = act_head[IDX_W-1:0]; pv_wd = cur_link;
        ac_we = 1'b1; ac_wa = cur; ac_wd = 1'b1;
      end
      CMD_A4: begin
        pv_we = 1'b1; pv_wa = cur; pv_wd = NIL;
      end
      CMD_F2: begin
        pv_we = (rd_next != NIL); pv_wa = rd_next[IDX_W-1:0]; pv_wd = rd_prev;
        nx_we = (rd_prev != NIL); nx_wa = rd_prev[IDX_W-1:0]; nx_wd = rd_next;
      end
      CMD_F3: begin
        pv_we = (spare_head != NIL); pv_wa = spare_head[IDX_W-1:0]; pv_wd = cur_link;
        nx_we = 1'b1; nx_wa = cur; nx_wd = spare_head;
      end
      CMD_F4: begin
        pv_we = 1'b1; pv_wa = cur; pv_wd = NIL;
        ac_we = 1'b1; ac_wa = cur; ac_wd = 1'b0;
      end
      CMD_P2: begin
        kd_we = 1'b1; kd_wa = cur; kd_wd = kind_in;
        qn_we = (qtail != NIL); qn_wa = qtail[IDX_W-1:0]; qn_wd = cur_link;
      end
      CMD_P3: begin
        qn_we = 1'b1; qn_wa = cur; qn_wd = NIL;
        qd_we = 1'b1; qd_wa = cur; qd_wd = 1'b1;
      end
      CMD_Q2: begin
        qn_we = 1'b1; qn_wa = cur; qn_wd = NIL;
        qd_we = 1'b1; qd_wa = cur; qd_wd = 1'b0;
      end
      default: begin
        nx_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (cmd == CMD_LOAD) rd_next <= next_mem[ra_pool];
  end

  always_ff @(posedge clk) begin
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (cmd == CMD_LOAD) rd_prev <= prev_mem[ra_pool];
  end

  always_ff @(posedge clk) begin
    if (qn_we) qnext_mem[qn_wa] <= qn_wd;
    if (cmd == CMD_LOAD) rd_qnext <= qnext_mem[ra_q];
  end

  always_ff @(posedge clk) begin
    if (kd_we) kind_mem[kd_wa] <= kd_wd;
    if (cmd == CMD_LOAD) rd_kind <= kind_mem[ra_q];
  end

  always_ff @(posedge clk) begin
    if (ac_we) active_mem[ac_wa] <= ac_wd;
    if (cmd == CMD_LOAD) rd_active <= active_mem[ra_pool];
  end

  always_ff @(posedge clk) begin
    if (qd_we) queued_mem[qd_wa] <= qd_wd;
    if (cmd == CMD_LOAD) rd_queued <= queued_mem[ra_pool];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      spare_head <= '0;
      act_head   <= NIL;
      qhead      <= NIL;
      qtail      <= NIL;
      alloc_cnt  <= '0;
      qlen       <= '0;
    end else begin
      case (cmd)
        CMD_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
        end
        CMD_A2: begin
          spare_head <= rd_next;
        end
        CMD_A4: begin
          act_head  <= cur_link;
          alloc_cnt <= alloc_cnt + LINK_W'(1);
        end
        CMD_F2: begin
          if (rd_prev == NIL) begin
            act_head <= rd_next;
          end
        end
        CMD_F4: begin
          spare_head <= cur_link;
          alloc_cnt  <= alloc_cnt - LINK_W'(1);
        end
        CMD_P2: begin
          if (qtail == NIL) begin
            qhead <= cur_link;
          end
        end
        CMD_P3: begin
          qtail <= cur_link;
          qlen  <= qlen + LINK_W'(1);
        end
        CMD_Q2: begin
          qhead <= rd_qnext;
          if (rd_qnext == NIL) begin
            qtail <= NIL;
          end
          qlen <= qlen - LINK_W'(1);
        end
        default: begin
          clr_idx <= clr_idx;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op          <= op_t'(mode);
        kind_in     <= task_kind;
        in_pool     <= (32'(handle) < 32'(POOL_ENTRIES));
        pend_status <= STS_DONE;
        pend_hout   <= '0;
        pend_kout   <= '0;
        case (op_t'(mode))
          OP_ALLOC: cur <= spare_head[IDX_W-1:0];
          OP_POP:   cur <= qhead[IDX_W-1:0];
          default:  cur <= hidx;
        endcase
      end
      CMD_A2: begin
        pend_hout <= cur;
      end
      CMD_Q2: begin
        pend_hout <= cur;
        pend_kout <= rd_kind;
      end
      CMD_FAIL_ALLOC: begin
        pend_status <= STS_EXHAUSTED;
      end
      CMD_FAIL_POP: begin
        pend_status <= STS_EMPTY;
      end
      CMD_WB: begin
        status       <= pend_status;
        handle_out   <= HANDLE_W'(pend_hout);
        kind_out     <= pend_kout;
        active_count <= COUNT_W'(alloc_cnt);
        queued_count <= COUNT_W'(qlen);
        list_head    <= (act_head != NIL) ? HANDLE_W'(act_head) : '0;
        active_empty <= (act_head == NIL);
      end
      default: begin
        pend_status <= pend_status;
      end
    endcase
  end

endmodule

// ----- rtl/linked_task_pool_and_queue_unit.sv -----
// Linked task pool and queue unit: top level joining controller and datapath.
// After reset a clearing pass over all 1024 entries initialises the memories;
// in_stall stays high throughout it. Each word is loaded, then decided on, and
// passes through ST_A3 and ST_A4 (alloc), ST_F3 and ST_F4 (free) or ST_P3 (push)
// before ST_WB writes its result; pop and failed or ignored operations go
// straight to ST_WB. One word is in flight at a time, as steps update links.
module linked_task_pool_and_queue_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ltpq_pkg::MODE_W-1:0]   mode,
  input  logic [ltpq_pkg::HANDLE_W-1:0] handle,
  input  logic [ltpq_pkg::KIND_W-1:0]   task_kind,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ltpq_pkg::STATUS_W-1:0] status,
  output logic [ltpq_pkg::HANDLE_W-1:0] handle_out,
  output logic [ltpq_pkg::KIND_W-1:0]   kind_out,
  output logic [ltpq_pkg::COUNT_W-1:0]  active_count,
  output logic [ltpq_pkg::COUNT_W-1:0]  queued_count,
  output logic [ltpq_pkg::HANDLE_W-1:0] list_head,
  output logic                          active_empty
);
  import ltpq_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  ltpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ltpq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .handle       (handle),
    .task_kind    (task_kind),
    .status       (status),
    .handle_out   (handle_out),
    .kind_out     (kind_out),
    .active_count (active_count),
    .queued_count (queued_count),
    .list_head    (list_head),
    .active_empty (active_empty)
  );

endmodule
